// ----- hdl/sfr_pkg.sv -----
package sfr_pkg;

  localparam int MaxPayloadDef = 32;
  localparam int LenW          = 7;
  localparam int SeenW         = 7;
  localparam int IdxW          = 6;
  localparam int CfgDataW      = 16;
  localparam int CfgIdxW       = 2;
  localparam int HeaderBytes   = 5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_VERSION   = 3'd1,
    ST_DIRECTION = 3'd2,
    ST_LENGTH    = 3'd3,
    ST_CHECKSUM  = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_BYTE = 2'd0,
    REG_VERSION    = 2'd1,
    REG_DIRECTION  = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  protocol_version;
    logic [7:0]  accepted_direction;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic in_frame;
    logic dumping;
  } ctrl_status_t;

endpackage

// ----- hdl/sfr_ram.sv -----
module sfr_ram #(
  parameter int DEPTH  = sfr_pkg::MaxPayloadDef,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sfr_ctrl.sv -----
module sfr_ctrl #(
  parameter int MAX_PAYLOAD = sfr_pkg::MaxPayloadDef,
  parameter int ADDR_W      = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfr_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [7:0]           message_id_o,
  output logic [7:0]           payload_byte_o,
  output logic [5:0]           byte_index_o,
  output logic                 has_byte_o,
  output logic                 last_o,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [7:0]           ram_wdata_o,
  output logic                 ram_re_o,
  output logic [ADDR_W-1:0]    ram_raddr_o,
  input  logic [7:0]           ram_rdata_i,
  output sfr_pkg::ctrl_status_t status_flags_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);
  localparam logic [sfr_pkg::SeenW-1:0] HdrLast = sfr_pkg::SeenW'(sfr_pkg::HeaderBytes - 1);
  localparam logic [sfr_pkg::SeenW-1:0] HdrLen  = sfr_pkg::SeenW'(sfr_pkg::HeaderBytes);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_HEADER  = 5'b00010,
    S_PAYLOAD = 5'b00100,
    S_READ    = 5'b01000,
    S_EMIT    = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [sfr_pkg::SeenW-1:0]   seen_q, seen_d;
  logic [7:0]                  id_q, id_d;
  logic [sfr_pkg::LenW-1:0]    len_q, len_d;
  logic [7:0]                  xor_q, xor_d;
  logic [15:0]                 ticks_q, ticks_d;
  sfr_pkg::status_e            fault_q, fault_d, fault_n;
  logic [sfr_pkg::IdxW-1:0]    idx_q, idx_d;

  logic                        out_valid_q, out_valid_d;
  logic [2:0]                  out_status_q, out_status_d;
  logic [7:0]                  out_byte_q, out_byte_d;
  logic [5:0]                  out_idx_q, out_idx_d;
  logic                        out_has_q, out_has_d;
  logic                        out_last_q, out_last_d;
  logic [7:0]                  out_id_q, out_id_d;
  logic                        out_load;

  logic                        out_free;
  logic                        rx_state;
  logic                        in_acc;
  logic [sfr_pkg::SeenW-1:0]   off;
  logic                        dump_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign rx_state   = (state_q == S_IDLE) || (state_q == S_HEADER) || (state_q == S_PAYLOAD);
  assign in_stall_o = !(rx_state && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign off        = seen_q - HdrLen;
  assign dump_last  = (sfr_pkg::LenW'(idx_q) + 1'b1) == len_q;

  always_comb begin
    state_d      = state_q;
    seen_d       = seen_q;
    id_d         = id_q;
    len_d        = len_q;
    xor_d        = xor_q;
    ticks_d      = ticks_q;
    fault_d      = fault_q;
    fault_n      = fault_q;
    idx_d        = idx_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    out_load     = 1'b0;
    out_status_d = sfr_pkg::ST_OK;
    out_byte_d   = 8'h00;
    out_idx_d    = 6'd0;
    out_has_d    = 1'b0;
    out_last_d   = 1'b1;
    out_id_d     = id_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && !mode_i && (rx_byte_i == cfg_i.start_byte)) begin
          state_d = S_HEADER;
          seen_d  = sfr_pkg::SeenW'(1);
          xor_d   = rx_byte_i;
          ticks_d = 16'd0;
          fault_d = sfr_pkg::ST_OK;
        end
      end
      S_HEADER, S_PAYLOAD: begin
        if (in_acc) begin
          if (mode_i) begin
            if (ticks_q >= cfg_i.timeout_ticks) begin
              state_d = S_IDLE;
              seen_d  = '0;
              xor_d   = 8'h00;
              ticks_d = 16'd0;
              fault_d = sfr_pkg::ST_OK;
            end else begin
              ticks_d = ticks_q + 16'd1;
            end
          end else if (state_q == S_HEADER) begin
            ticks_d = 16'd0;
            priority if (seen_q == sfr_pkg::SeenW'(1)) begin
              if (rx_byte_i != cfg_i.protocol_version) fault_n = sfr_pkg::ST_VERSION;
            end else if (seen_q == sfr_pkg::SeenW'(2)) begin
              id_d = rx_byte_i;
            end else if (seen_q == sfr_pkg::SeenW'(3)) begin
              if (fault_q == sfr_pkg::ST_OK && rx_byte_i != cfg_i.accepted_direction)
                fault_n = sfr_pkg::ST_DIRECTION;
            end else begin
              if (fault_q == sfr_pkg::ST_OK && rx_byte_i > MaxLen)
                fault_n = sfr_pkg::ST_LENGTH;
            end
            xor_d   = xor_q ^ rx_byte_i;
            seen_d  = seen_q + 1'b1;
            fault_d = fault_n;
            if (seen_q >= HdrLast) begin
              if (fault_n != sfr_pkg::ST_OK) begin
                out_load     = 1'b1;
                out_status_d = fault_n;
                state_d      = S_IDLE;
                seen_d       = '0;
                xor_d        = 8'h00;
                fault_d      = sfr_pkg::ST_OK;
              end else begin
                len_d   = rx_byte_i[sfr_pkg::LenW-1:0];
                state_d = S_PAYLOAD;
              end
            end
          end else begin
            ticks_d = 16'd0;
            if (off < len_q) begin
              ram_we_o = 1'b1;
              xor_d    = xor_q ^ rx_byte_i;
              seen_d   = seen_q + 1'b1;
            end else begin
              state_d = S_IDLE;
              seen_d  = '0;
              xor_d   = 8'h00;
              fault_d = sfr_pkg::ST_OK;
              if (rx_byte_i != xor_q) begin
                out_load     = 1'b1;
                out_status_d = sfr_pkg::ST_CHECKSUM;
              end else if (len_q == '0) begin
                out_load = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_READ;
              end
            end
          end
        end
      end
      S_READ: begin
        ram_re_o = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = ram_rdata_i;
          out_idx_d  = idx_q;
          out_has_d  = 1'b1;
          out_last_d = dump_last;
          idx_d      = idx_q + 1'b1;
          state_d    = dump_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= '0;
      id_q        <= 8'h00;
      len_q       <= '0;
      xor_q       <= 8'h00;
      ticks_q     <= 16'd0;
      fault_q     <= sfr_pkg::ST_OK;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      id_q        <= id_d;
      len_q       <= len_d;
      xor_q       <= xor_d;
      ticks_q     <= ticks_d;
      fault_q     <= fault_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_byte_q   <= out_byte_d;
      out_idx_q    <= out_idx_d;
      out_has_q    <= out_has_d;
      out_last_q   <= out_last_d;
      out_id_q     <= out_id_d;
    end
  end

  assign ram_waddr_o    = off[ADDR_W-1:0];
  assign ram_wdata_o    = rx_byte_i;
  assign ram_raddr_o    = idx_q[ADDR_W-1:0];

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign message_id_o   = out_id_q;
  assign payload_byte_o = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign has_byte_o     = out_has_q;
  assign last_o         = out_last_q;

  assign status_flags_o.in_frame = (state_q == S_HEADER) || (state_q == S_PAYLOAD);
  assign status_flags_o.dumping  = (state_q == S_READ) || (state_q == S_EMIT);

endmodule

// ----- hdl/serial_frame_receiver.sv -----
// serial frame receiver
// input channel: in_valid_i / in_stall_o with mode_i and rx_byte_i; mode 0 is a
// received byte, mode 1 a millisecond tick. one request is taken per cycle
// while a frame is being collected and the output register is free.
// output channel: out_valid_o / out_stall_i with status, message id, payload
// byte, index, has_byte and last. an error or empty frame gives one result, a
// good frame one result per payload byte, last set on the final one.
// an error or empty result is in the output register at the edge that takes
// the closing byte; the first payload result is loaded after a read state and
// an emit state. each payload byte passes through a read state and an emit
// state for the synchronous memory read, during which no input is taken; the
// emit state waits while the output register is full.
// the output register decouples the sides: a new input is taken while a
// result is held, as long as that result leaves in the same cycle.
// stall on the output holds the result and stops input once the register is
// full. reset returns to hunting for the start byte and loads the register
// defaults; no memory clearing pass is needed.
// config writes (cfg_we_i, cfg_idx_i, cfg_data_i) are meant for idle periods.
module serial_frame_receiver #(
  parameter int MAX_PAYLOAD = sfr_pkg::MaxPayloadDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [7:0]                   message_id_o,
  output logic [7:0]                   payload_byte_o,
  output logic [5:0]                   byte_index_o,
  output logic                         has_byte_o,
  output logic                         last_o
);

  localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  sfr_pkg::cfg_t         cfg_q;
  sfr_pkg::ctrl_status_t flags;
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [AddrW-1:0]      ram_raddr;
  logic [7:0]            ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte         <= 8'hAA;
      cfg_q.protocol_version   <= 8'h01;
      cfg_q.accepted_direction <= 8'h00;
      cfg_q.timeout_ticks      <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (sfr_pkg::reg_idx_e'(cfg_idx_i))
        sfr_pkg::REG_START_BYTE: cfg_q.start_byte         <= cfg_data_i[7:0];
        sfr_pkg::REG_VERSION:    cfg_q.protocol_version   <= cfg_data_i[7:0];
        sfr_pkg::REG_DIRECTION:  cfg_q.accepted_direction <= cfg_data_i[7:0];
        sfr_pkg::REG_TIMEOUT:    cfg_q.timeout_ticks      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfr_ram #(
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfr_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .ADDR_W      (AddrW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .message_id_o   (message_id_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .has_byte_o     (has_byte_o),
    .last_o         (last_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .status_flags_o (flags)
  );

  a_dump_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags.dumping |-> in_stall_o)
    else $error("input taken during payload dump");

  a_empty_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> last_o)
    else $error("result without byte is not last");

  a_error_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 3'(sfr_pkg::ST_OK)) |-> !has_byte_o)
    else $error("error result carries a payload byte");

  a_no_frame_and_dump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags.dumping && flags.in_frame))
    else $error("collecting and dumping at once");

endmodule
